// ----- src/mrft_pkg.sv -----
// Package for the motor reply frame tracker: opcodes, result codes,
// reply framing constants and the structs passed between its modules.
// No dependencies.
package mrft_pkg;

  localparam int DEF_NUM_MOTORS = 8;

  localparam logic [7:0]  FRAME_END     = 8'h6B;
  localparam logic [7:0]  ERR_MARK      = 8'hEE;
  localparam logic [7:0]  CMD_SPEED     = 8'h35;
  localparam logic [7:0]  CMD_POSITION  = 8'h36;
  localparam logic [7:0]  SIGN_NEG      = 8'h01;
  localparam logic [3:0]  LEN_SPEED     = 4'd6;
  localparam logic [3:0]  LEN_POSITION  = 4'd8;
  localparam logic [3:0]  LEN_ERROR     = 4'd4;
  localparam logic [3:0]  RX_DEPTH      = 4'd8;
  localparam logic [15:0] RESET_TIMEOUT = 16'd20;

  localparam int VALUE_W = 33;
  localparam int SPD_W   = 17;

  typedef enum logic [2:0] {
    OP_ASK_SPD  = 3'd0,
    OP_ASK_POS  = 3'd1,
    OP_RX_BYTE  = 3'd2,
    OP_TICK     = 3'd3,
    OP_RD_SPD   = 3'd4,
    OP_RD_POS   = 3'd5,
    OP_LINE_ERR = 3'd6,
    OP_STATUS   = 3'd7
  } mrft_op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_PENDING = 2'd1,
    ST_ERROR   = 2'd2,
    ST_TIMEOUT = 2'd3
  } mrft_stat_t;

  typedef struct packed {
    mrft_stat_t status;
    logic       send;
    logic [7:0] cmd;
    logic       waiting;
    mrft_stat_t last_result;
    logic       done;
  } mrft_res_t;

  typedef struct packed {
    logic               spd_we;
    logic               pos_we;
    logic [7:0]         addr;
    logic [VALUE_W-1:0] value;
  } mrft_wr_t;

  function automatic logic addr_ok(input logic [7:0] a, input logic [7:0] n);
    return (a != 8'd0) && (a <= n);
  endfunction

endpackage

// ----- src/mrft_cache.sv -----
// Per-motor speed and position cache: two synchronous memories with a
// registered read, plus known flags. Depends on mrft_pkg.
module mrft_cache #(
  parameter int NUM_MOTORS = mrft_pkg::DEF_NUM_MOTORS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            accept,
  input  mrft_pkg::mrft_op_t              op,
  input  logic [7:0]                      rd_addr,
  input  mrft_pkg::mrft_wr_t              wr,
  output logic                            rd_known,
  output logic [mrft_pkg::VALUE_W-1:0]    rd_value
);
  import mrft_pkg::*;

  localparam int SLOT_W = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;

  typedef enum logic [1:0] {
    SEL_NONE = 2'd0,
    SEL_SPD  = 2'd1,
    SEL_POS  = 2'd2
  } sel_t;

  logic [SPD_W-1:0]   spd_mem [NUM_MOTORS];
  logic [VALUE_W-1:0] pos_mem [NUM_MOTORS];
  logic [SPD_W-1:0]   spd_q_r;
  logic [VALUE_W-1:0] pos_q_r;
  logic [NUM_MOTORS-1:0] spd_known_r;
  logic [NUM_MOTORS-1:0] pos_known_r;
  sel_t sel_r;
  sel_t sel_nxt;

  logic [7:0] rd_off;
  logic [7:0] wr_off;
  logic [SLOT_W-1:0] rd_slot;
  logic [SLOT_W-1:0] wr_slot;
  logic is_rd;
  logic is_pos;

  assign rd_off  = rd_addr - 8'd1;
  assign wr_off  = wr.addr - 8'd1;
  assign rd_slot = rd_off[SLOT_W-1:0];
  assign wr_slot = wr_off[SLOT_W-1:0];
  assign is_rd   = (op == OP_RD_SPD) || (op == OP_RD_POS);
  assign is_pos  = (op == OP_RD_POS);

  assign rd_known = is_pos ? pos_known_r[rd_slot] : spd_known_r[rd_slot];

  always_comb begin
    sel_nxt = SEL_NONE;
    if (is_rd && addr_ok(rd_addr, 8'(NUM_MOTORS)) && rd_known) begin
      sel_nxt = is_pos ? SEL_POS : SEL_SPD;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.spd_we) begin
      spd_mem[wr_slot] <= wr.value[SPD_W-1:0];
    end
    if (wr.pos_we) begin
      pos_mem[wr_slot] <= wr.value;
    end
    if (accept && is_rd) begin
      spd_q_r <= spd_mem[rd_slot];
      pos_q_r <= pos_mem[rd_slot];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spd_known_r <= '0;
      pos_known_r <= '0;
      sel_r       <= SEL_NONE;
    end else begin
      if (wr.spd_we) begin
        spd_known_r[wr_slot] <= 1'b1;
      end
      if (wr.pos_we) begin
        pos_known_r[wr_slot] <= 1'b1;
      end
      if (accept) begin
        sel_r <= sel_nxt;
      end
    end
  end

  always_comb begin
    unique case (sel_r)
      SEL_SPD: rd_value = {{(VALUE_W-SPD_W){spd_q_r[SPD_W-1]}}, spd_q_r};
      SEL_POS: rd_value = pos_q_r;
      default: rd_value = '0;
    endcase
  end

endmodule

// ----- src/mrft_exchange.sv -----
// Exchange tracker: start checks, reply byte parser, tick timeout and
// result codes; issues cache writes. Depends on mrft_pkg.
module mrft_exchange #(
  parameter int NUM_MOTORS = mrft_pkg::DEF_NUM_MOTORS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  mrft_pkg::mrft_op_t op,
  input  logic [7:0]         motor_address,
  input  logic [7:0]         rx_byte,
  input  logic [15:0]        timeout_ticks,
  input  logic               rd_known,
  output mrft_pkg::mrft_res_t res,
  output mrft_pkg::mrft_wr_t  wr
);
  import mrft_pkg::*;

  logic        waiting_r,  waiting_nxt;
  logic        kind_pos_r, kind_pos_nxt;
  logic [7:0]  paddr_r,    paddr_nxt;
  logic [3:0]  idx_r,      idx_nxt;
  logic [3:0]  len_r,      len_nxt;
  logic        b0ok_r,     b0ok_nxt;
  logic [7:0]  b1_r,       b1_nxt;
  logic        sign_r,     sign_nxt;
  logic [31:0] mag_r,      mag_nxt;
  logic [15:0] elapsed_r,  elapsed_nxt;
  mrft_stat_t  outcome_r,  outcome_nxt;

  logic        fin;
  mrft_stat_t  fin_code;
  logic [3:0]  nidx;
  logic [7:0]  cmd_cur;
  logic [VALUE_W-1:0] mag_ext;
  logic [VALUE_W-1:0] sval;
  logic        addr_good;

  assign nidx      = idx_r + 4'd1;
  assign cmd_cur   = kind_pos_r ? CMD_POSITION : CMD_SPEED;
  assign mag_ext   = kind_pos_r ? {1'b0, mag_r} : {17'd0, mag_r[15:0]};
  assign sval      = sign_r ? (~mag_ext + 33'd1) : mag_ext;
  assign addr_good = addr_ok(motor_address, 8'(NUM_MOTORS));

  always_comb begin
    waiting_nxt  = waiting_r;
    kind_pos_nxt = kind_pos_r;
    paddr_nxt    = paddr_r;
    idx_nxt      = idx_r;
    len_nxt      = len_r;
    b0ok_nxt     = b0ok_r;
    b1_nxt       = b1_r;
    sign_nxt     = sign_r;
    mag_nxt      = mag_r;
    elapsed_nxt  = elapsed_r;
    outcome_nxt  = outcome_r;
    fin          = 1'b0;
    fin_code     = ST_ERROR;
    res          = '0;
    res.status   = ST_OK;
    wr           = '0;
    wr.addr      = paddr_r;
    wr.value     = sval;

    unique case (op)
      OP_ASK_SPD, OP_ASK_POS: begin
        if (!addr_good) begin
          res.status = ST_ERROR;
        end else if (waiting_r) begin
          res.status = ST_PENDING;
        end else begin
          kind_pos_nxt = (op == OP_ASK_POS);
          paddr_nxt    = motor_address;
          len_nxt      = (op == OP_ASK_POS) ? LEN_POSITION : LEN_SPEED;
          idx_nxt      = 4'd0;
          elapsed_nxt  = 16'd0;
          outcome_nxt  = ST_PENDING;
          waiting_nxt  = 1'b1;
          res.send     = 1'b1;
          res.cmd      = (op == OP_ASK_POS) ? CMD_POSITION : CMD_SPEED;
        end
      end
      OP_RX_BYTE: begin
        if (waiting_r) begin
          if (idx_r >= RX_DEPTH) begin
            fin = 1'b1;
          end else begin
            idx_nxt = nidx;
            priority if (idx_r == 4'd0) begin
              b0ok_nxt = (rx_byte == paddr_r);
            end else if (idx_r == 4'd1) begin
              b1_nxt = rx_byte;
            end else if (idx_r == 4'd2) begin
              priority if (!b0ok_r) begin
                fin = 1'b1;
              end else if (b1_r == 8'h00 && rx_byte == ERR_MARK) begin
                len_nxt = LEN_ERROR;
              end else if (b1_r != cmd_cur ||
                           (rx_byte != 8'h00 && rx_byte != SIGN_NEG)) begin
                fin = 1'b1;
              end else begin
                sign_nxt = rx_byte[0];
              end
            end else if (nidx >= len_r) begin
              fin = 1'b1;
              if (rx_byte == FRAME_END && len_r != LEN_ERROR) begin
                fin_code  = ST_OK;
                wr.spd_we = !kind_pos_r;
                wr.pos_we = kind_pos_r;
              end
            end else begin
              mag_nxt = {mag_r[23:0], rx_byte};
            end
          end
          res.status = fin ? fin_code : ST_PENDING;
        end
      end
      OP_TICK: begin
        if (waiting_r) begin
          elapsed_nxt = (elapsed_r == 16'hFFFF) ? elapsed_r : elapsed_r + 16'd1;
          if (elapsed_nxt > timeout_ticks) begin
            fin        = 1'b1;
            fin_code   = ST_TIMEOUT;
            res.status = ST_TIMEOUT;
          end else begin
            res.status = ST_PENDING;
          end
        end
      end
      OP_RD_SPD, OP_RD_POS: begin
        if (!addr_good) begin
          res.status = ST_ERROR;
        end else if (!rd_known) begin
          res.status = ST_PENDING;
        end
      end
      OP_LINE_ERR: begin
        fin        = 1'b1;
        res.status = ST_ERROR;
      end
      OP_STATUS: begin
        res.status = outcome_r;
      end
    endcase

    if (fin) begin
      waiting_nxt = 1'b0;
      outcome_nxt = fin_code;
      res.done    = waiting_r;
    end
    if (!accept) begin
      wr.spd_we = 1'b0;
      wr.pos_we = 1'b0;
    end
    res.waiting     = waiting_nxt;
    res.last_result = outcome_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      waiting_r  <= 1'b0;
      kind_pos_r <= 1'b0;
      paddr_r    <= 8'd0;
      idx_r      <= 4'd0;
      len_r      <= 4'd0;
      b0ok_r     <= 1'b0;
      b1_r       <= 8'd0;
      sign_r     <= 1'b0;
      mag_r      <= 32'd0;
      elapsed_r  <= 16'd0;
      outcome_r  <= ST_OK;
    end else if (accept) begin
      waiting_r  <= waiting_nxt;
      kind_pos_r <= kind_pos_nxt;
      paddr_r    <= paddr_nxt;
      idx_r      <= idx_nxt;
      len_r      <= len_nxt;
      b0ok_r     <= b0ok_nxt;
      b1_r       <= b1_nxt;
      sign_r     <= sign_nxt;
      mag_r      <= mag_nxt;
      elapsed_r  <= elapsed_nxt;
      outcome_r  <= outcome_nxt;
    end
  end

endmodule

// ----- src/motor_reply_frame_tracker.sv -----
// Top level of the motor reply frame tracker: stream ports, timeout
// register, output register. Depends on mrft_pkg, mrft_exchange, mrft_cache.
//
// Every input word yields exactly one result word. A word is taken in every
// cycle while the output register is empty or being drained, so the block
// sustains one word per clock; its result is in the output register in the
// cycle after acceptance, as the speed and position cache memories also have
// a registered read. After reset the block is ready at once; write
// timeout_ticks only while no word is in flight.
module motor_reply_frame_tracker #(
  parameter int NUM_MOTORS = mrft_pkg::DEF_NUM_MOTORS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // motor_address[7:0], rx_byte[15:8]
  input  logic [2:0]  in_tuser,   // opcode[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  // status[1:0], send_request[2], send_command[10:3], value[43:11],
  // waiting[44], last_result[46:45], reply_done[47]
  output logic [47:0] out_tdata,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);
  import mrft_pkg::*;

  logic               accept;
  mrft_op_t           op;
  logic [15:0]        timeout_r;
  logic               out_valid_r;
  mrft_res_t          res;
  mrft_res_t          res_r;
  mrft_wr_t           wr;
  logic               rd_known;
  logic [VALUE_W-1:0] rd_value;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign op        = mrft_op_t'(in_tuser);

  mrft_exchange #(.NUM_MOTORS(NUM_MOTORS)) u_exchange (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .op            (op),
    .motor_address (in_tdata[7:0]),
    .rx_byte       (in_tdata[15:8]),
    .timeout_ticks (timeout_r),
    .rd_known      (rd_known),
    .res           (res),
    .wr            (wr)
  );

  mrft_cache #(.NUM_MOTORS(NUM_MOTORS)) u_cache (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .op       (op),
    .rd_addr  (in_tdata[7:0]),
    .wr       (wr),
    .rd_known (rd_known),
    .rd_value (rd_value)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r   <= RESET_TIMEOUT;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        timeout_r <= cfg_wr_data;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {res_r.done, res_r.last_result, res_r.waiting, rd_value,
                       res_r.cmd, res_r.send, res_r.status};

  a_send_starts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.send |-> res_r.status == ST_OK && res_r.waiting)
    else $error("send without accepted start");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.done |-> !res_r.waiting)
    else $error("finished exchange still waiting");

  a_wait_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.waiting |-> res_r.last_result == ST_PENDING)
    else $error("waiting without pending outcome");

  a_value_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && rd_value != '0 |-> res_r.status == ST_OK)
    else $error("value on failed read");

endmodule

// ----- tb/motor_reply_frame_tracker_test.sv -----
`timescale 1ns / 100ps
// Self-checking bench for motor_reply_frame_tracker: directed query/reply cases,
// timeout settings, random traffic under idling and backpressure, long waits.
// Depends on mrft_pkg and motor_reply_frame_tracker.
module motor_reply_frame_tracker_test;
  import mrft_pkg::*;

  localparam int MOTORS = DEF_NUM_MOTORS;
  localparam int CYCLE_LIMIT = 1000000;

  typedef enum logic [1:0] {
    KIND_NONE     = 2'd0,
    KIND_SPEED    = 2'd1,
    KIND_POSITION = 2'd2
  } ask_kind_t;

  typedef struct packed {
    logic        done;
    mrft_stat_t  last;
    logic        waiting;
    logic [32:0] value;
    logic [7:0]  cmd;
    logic        send;
    mrft_stat_t  status;
  } result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;

  motor_reply_frame_tracker uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // tracker copy
  logic [15:0] timeout_limit = RESET_TIMEOUT;
  logic        busy = 1'b0;
  ask_kind_t   ask_kind = KIND_NONE;
  logic [7:0]  want_addr = '0;
  logic [7:0]  want_cmd = '0;
  logic [3:0]  rx_count = '0;
  logic [3:0]  rx_len = '0;
  logic [7:0]  rx_buf [8];
  logic [15:0] tick_count = '0;
  mrft_stat_t  outcome = ST_OK;
  logic [32:0] spd_cache [MOTORS];
  logic [32:0] pos_cache [MOTORS];
  logic        spd_known [MOTORS];
  logic        pos_known [MOTORS];

  result_t     tracker_results [$];
  int          words_sent = 0;
  int          words_seen = 0;
  int          mismatches = 0;
  int          exchange_ends [4] = '{0, 0, 0, 0};
  int          cycle_count = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          hold_left = 0;
  logic [15:0] cfg_timeout_now = RESET_TIMEOUT;

  initial begin
    for (int i = 0; i < MOTORS; i++) begin
      spd_known[i] = 1'b0;
      pos_known[i] = 1'b0;
      spd_cache[i] = '0;
      pos_cache[i] = '0;
    end
    for (int i = 0; i < 8; i++) rx_buf[i] = '0;
  end

  function automatic logic motor_in_range(logic [7:0] a);
    return a >= 8'd1 && a <= MOTORS;
  endfunction

  function automatic void close_exchange(mrft_stat_t o);
    outcome = o;
    busy = 1'b0;
    ask_kind = KIND_NONE;
  endfunction

  function automatic result_t tracker_step(mrft_op_t op, logic [7:0] addr, logic [7:0] rx);
    result_t     r;
    logic        abort;
    logic [32:0] mag;
    r = '0;
    case (op)
      OP_ASK_SPD, OP_ASK_POS: begin
        if (!motor_in_range(addr)) begin
          r.status = ST_ERROR;
        end else if (busy) begin
          r.status = ST_PENDING;
        end else begin
          want_addr = addr;
          want_cmd = (op == OP_ASK_SPD) ? CMD_SPEED : CMD_POSITION;
          ask_kind = (op == OP_ASK_SPD) ? KIND_SPEED : KIND_POSITION;
          rx_len = (op == OP_ASK_SPD) ? LEN_SPEED : LEN_POSITION;
          rx_count = '0;
          tick_count = '0;
          outcome = ST_PENDING;
          busy = 1'b1;
          r.send = 1'b1;
          r.cmd = want_cmd;
        end
      end
      OP_RX_BYTE: begin
        if (busy) begin
          r.done = 1'b1;
          if (rx_count >= RX_DEPTH) begin
            close_exchange(ST_ERROR);
          end else begin
            rx_buf[rx_count[2:0]] = rx;
            rx_count++;
            abort = 1'b0;
            if (rx_count == 4'd3) begin
              if (rx_buf[0] != want_addr) begin
                abort = 1'b1;
              end else if (rx_buf[1] == 8'h00 && rx_buf[2] == ERR_MARK) begin
                rx_len = LEN_ERROR;
              end else if (rx_buf[1] != want_cmd ||
                           (rx_buf[2] != 8'h00 && rx_buf[2] != SIGN_NEG)) begin
                abort = 1'b1;
              end
            end
            if (abort) begin
              close_exchange(ST_ERROR);
            end else if (rx_count < rx_len) begin
              r.done = 1'b0;
            end else if (rx_len < LEN_ERROR || rx_len > RX_DEPTH || rx_buf[0] != want_addr ||
                         rx_buf[rx_len - 4'd1] != FRAME_END) begin
              close_exchange(ST_ERROR);
            end else if (rx_buf[1] == 8'h00 && rx_buf[2] == ERR_MARK) begin
              close_exchange(ST_ERROR);
            end else if (rx_buf[1] != want_cmd || !motor_in_range(want_addr) ||
                         (rx_buf[2] != 8'h00 && rx_buf[2] != SIGN_NEG)) begin
              close_exchange(ST_ERROR);
            end else if (ask_kind == KIND_SPEED && rx_len == LEN_SPEED) begin
              mag = {17'd0, rx_buf[3], rx_buf[4]};
              spd_cache[want_addr - 8'd1] = (rx_buf[2] == SIGN_NEG) ? -mag : mag;
              spd_known[want_addr - 8'd1] = 1'b1;
              close_exchange(ST_OK);
            end else if (ask_kind == KIND_POSITION && rx_len == LEN_POSITION) begin
              mag = {1'b0, rx_buf[3], rx_buf[4], rx_buf[5], rx_buf[6]};
              pos_cache[want_addr - 8'd1] = (rx_buf[2] == SIGN_NEG) ? -mag : mag;
              pos_known[want_addr - 8'd1] = 1'b1;
              close_exchange(ST_OK);
            end else begin
              close_exchange(ST_ERROR);
            end
          end
          r.status = r.done ? outcome : ST_PENDING;
        end
      end
      OP_TICK: begin
        if (busy) begin
          if (tick_count != 16'hFFFF) tick_count++;
          if (tick_count > timeout_limit) begin
            close_exchange(ST_TIMEOUT);
            r.done = 1'b1;
            r.status = ST_TIMEOUT;
          end else begin
            r.status = ST_PENDING;
          end
        end
      end
      OP_RD_SPD, OP_RD_POS: begin
        if (!motor_in_range(addr)) begin
          r.status = ST_ERROR;
        end else if (op == OP_RD_SPD) begin
          if (!spd_known[addr - 8'd1]) r.status = ST_PENDING;
          else r.value = spd_cache[addr - 8'd1];
        end else begin
          if (!pos_known[addr - 8'd1]) r.status = ST_PENDING;
          else r.value = pos_cache[addr - 8'd1];
        end
      end
      OP_LINE_ERR: begin
        r.done = busy;
        close_exchange(ST_ERROR);
        r.status = ST_ERROR;
      end
      OP_STATUS: r.status = outcome;
    endcase
    r.waiting = busy;
    r.last = outcome;
    return r;
  endfunction

  always @(posedge clk) begin
    result_t got, want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = result_t'(out_tdata);
        words_seen++;
        if (tracker_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("result word %h with nothing outstanding", out_tdata);
        end else begin
          want = tracker_results.pop_front();
          if (got.status !== want.status || got.send !== want.send || got.cmd !== want.cmd ||
              got.value !== want.value || got.waiting !== want.waiting ||
              got.last !== want.last || got.done !== want.done) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: expected st=%0d req=%0d cmd=%h val=%h wait=%0d last=%0d ",
                        "done=%0d, got st=%0d req=%0d cmd=%h val=%h wait=%0d last=%0d done=%0d"},
                       want.status, want.send, want.cmd, want.value, want.waiting, want.last,
                       want.done, got.status, got.send, got.cmd, got.value, got.waiting,
                       got.last, got.done);
          end
        end
      end
      if (cfg_wr_en) timeout_limit = cfg_wr_data;
      if (in_tvalid && in_tready) begin
        want = tracker_step(mrft_op_t'(in_tuser), in_tdata[7:0], in_tdata[15:8]);
        tracker_results.push_back(want);
        if (want.done) exchange_ends[want.last]++;
      end
    end
  end

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  task automatic send_word(input mrft_op_t op, input logic [7:0] addr, input logic [7:0] data);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {data, addr};
    do @(posedge clk); while (!in_tready);
    words_sent++;
    if ($urandom_range(99) < idle_pct) begin
      gap = $urandom_range(1, 3);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (words_seen < words_sent);
  endtask

  task automatic write_timeout(input logic [15:0] ticks);
    wait_for_results();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= ticks;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cfg_timeout_now = ticks;
  endtask

  task automatic set_idling(input int send_idle, input int recv_stall);
    idle_pct = send_idle;
    stall_pct = recv_stall;
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_word(OP_TICK, 8'($urandom), 8'($urandom));
  endtask

  function automatic logic [63:0] reply_frame(ask_kind_t kind, logic [7:0] addr,
                                             logic [7:0] sign, logic [31:0] mag);
    if (kind == KIND_SPEED)
      return {16'h0, FRAME_END, mag[7:0], mag[15:8], sign, CMD_SPEED, addr};
    return {FRAME_END, mag[7:0], mag[15:8], mag[23:16], mag[31:24], sign, CMD_POSITION, addr};
  endfunction

  function automatic logic [63:0] error_frame(logic [7:0] addr, logic [7:0] trailer);
    return {32'h0, trailer, ERR_MARK, 8'h00, addr};
  endfunction

  // interleave reads, ticks and status queries between reply bytes
  task automatic send_reply(input logic [63:0] frame, input int n, input int side_pct);
    mrft_op_t side;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < side_pct) begin
        case ($urandom_range(3))
          0: side = OP_TICK;
          1: side = OP_STATUS;
          2: side = OP_RD_SPD;
          default: side = OP_RD_POS;
        endcase
        send_word(side, 8'($urandom_range(0, MOTORS + 1)), 8'($urandom));
      end
      send_word(OP_RX_BYTE, 8'($urandom), frame[8*i +: 8]);
    end
  endtask

  task automatic test_requests_and_reads();
    set_idling(0, 0);
    send_word(OP_STATUS, 8'd0, 8'd0);
    send_word(OP_RD_SPD, 8'd1, 8'd0);
    send_word(OP_RD_POS, 8'd0, 8'd0);
    send_word(OP_RD_SPD, 8'hFF, 8'hFF);
    send_word(OP_ASK_SPD, 8'd0, 8'd0);
    send_word(OP_ASK_POS, 8'd9, 8'd0);
    send_word(OP_RX_BYTE, 8'hFF, 8'hFF);
    send_word(OP_TICK, 8'd0, 8'd0);
    send_word(OP_LINE_ERR, 8'd0, 8'd0);
    send_word(OP_STATUS, 8'd0, 8'd0);
  endtask

  task automatic test_good_replies();
    send_word(OP_ASK_SPD, 8'd1, 8'd0);
    send_word(OP_ASK_POS, 8'd2, 8'd0);
    send_reply(reply_frame(KIND_SPEED, 8'd1, 8'h00, 32'h0000FFFF), int'(LEN_SPEED), 0);
    send_word(OP_RD_SPD, 8'd1, 8'd0);
    send_word(OP_ASK_POS, 8'd8, 8'd0);
    send_reply(reply_frame(KIND_POSITION, 8'd8, SIGN_NEG, 32'hFFFFFFFF), int'(LEN_POSITION), 0);
    send_word(OP_RD_POS, 8'd8, 8'd0);
    send_word(OP_RD_POS, 8'd1, 8'd0);
  endtask

  task automatic test_broken_replies();
    send_word(OP_ASK_SPD, 8'd2, 8'd0);
    send_reply(error_frame(8'd2, FRAME_END), int'(LEN_ERROR), 0);
    send_word(OP_ASK_POS, 8'd4, 8'd0);
    send_reply(reply_frame(KIND_POSITION, 8'd4, 8'h00, 32'h0), 2, 0);
    send_word(OP_LINE_ERR, 8'd0, 8'd0);
  endtask

  task automatic test_tick_timeout();
    send_word(OP_ASK_SPD, 8'd4, 8'd0);
    send_ticks(int'(RESET_TIMEOUT) + 1);
    write_timeout(16'd0);
    send_word(OP_ASK_POS, 8'd5, 8'd0);
    send_ticks(1);
    write_timeout(16'd1);
    send_word(OP_ASK_SPD, 8'd6, 8'd0);
    send_ticks(3);
    send_word(OP_STATUS, 8'd0, 8'd0);
  endtask

  task automatic random_exchange();
    ask_kind_t   kind;
    logic [7:0]  addr;
    logic [7:0]  sign;
    logic [31:0] mag;
    logic [63:0] frame;
    int          n;
    int          mode;
    int          idx;
    kind = $urandom_range(1) ? KIND_SPEED : KIND_POSITION;
    addr = ($urandom_range(19) == 0) ? 8'($urandom) : 8'($urandom_range(1, MOTORS));
    sign = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(1));
    case ($urandom_range(7))
      0: mag = '0;
      1: mag = '1;
      default: mag = $urandom;
    endcase
    frame = reply_frame(kind, addr, sign, mag);
    n = (kind == KIND_SPEED) ? int'(LEN_SPEED) : int'(LEN_POSITION);
    mode = $urandom_range(99);
    if (mode >= 60 && mode < 78) begin
      idx = ($urandom_range(1) == 0) ? $urandom_range(2) : $urandom_range(n - 1);
      frame[8*idx +: 8] = 8'($urandom);
    end else if (mode >= 78 && mode < 86) begin
      frame = error_frame(addr, ($urandom_range(3) == 0) ? 8'($urandom) : FRAME_END);
      n = int'(LEN_ERROR);
    end else if (mode >= 86) begin
      n = $urandom_range(0, n - 1);
    end
    send_word((kind == KIND_SPEED) ? OP_ASK_SPD : OP_ASK_POS, addr, 8'($urandom));
    send_reply(frame, n, 10);
    if (mode >= 86) begin
      if (cfg_timeout_now < 64 && $urandom_range(3) != 0) send_ticks(cfg_timeout_now + 1);
      else send_word(OP_LINE_ERR, 8'($urandom), 8'($urandom));
    end
  endtask

  task automatic run_traffic(input int words);
    int target;
    mrft_op_t op;
    target = words_sent + words;
    while (words_sent < target) begin
      if ($urandom_range(99) < 70) begin
        random_exchange();
      end else begin
        op = ($urandom_range(19) == 0) ? mrft_op_t'($urandom_range(1))
                                       : mrft_op_t'($urandom_range(2, 7));
        send_word(op, ($urandom_range(1) == 0) ? 8'($urandom_range(1, MOTORS)) : 8'($urandom),
                  8'($urandom));
      end
    end
  endtask

  task automatic test_random_traffic();
    set_idling(0, 0);
    run_traffic(400);
    write_timeout(16'($urandom_range(2, 40)));
    set_idling(67, 0);
    run_traffic(400);
    write_timeout(16'hFFFF);
    set_idling(0, 67);
    run_traffic(400);
    write_timeout(16'($urandom_range(0, 6)));
    set_idling(21, 21);
    run_traffic(400);
  endtask

  task automatic test_output_backpressure();
    logic [7:0] addr;
    set_idling(0, 0);
    write_timeout(RESET_TIMEOUT);
    repeat (3) begin
      addr = 8'($urandom_range(1, MOTORS));
      hold_left = $urandom_range(30, 60);
      send_word(OP_ASK_SPD, addr, 8'd0);
      send_reply(reply_frame(KIND_SPEED, addr, 8'($urandom_range(1)), $urandom),
                 int'(LEN_SPEED), 0);
      send_word(OP_RD_SPD, addr, 8'd0);
      send_word(OP_STATUS, 8'd0, 8'd0);
      wait_for_results();
    end
  endtask

  task automatic test_long_wait();
    set_idling(0, 0);
    write_timeout(16'd100);
    send_word(OP_ASK_POS, 8'd3, 8'd0);
    send_ticks(100);
    send_word(OP_STATUS, 8'd0, 8'd0);
    send_ticks(1);
    send_word(OP_LINE_ERR, 8'd0, 8'd0);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_requests_and_reads();
    test_good_replies();
    test_broken_replies();
    test_tick_timeout();
    test_random_traffic();
    test_output_backpressure();
    test_long_wait();
    wait_for_results();
    repeat (4) @(posedge clk);
    if (tracker_results.size() != 0) mismatches += tracker_results.size();
    $display("%0d words checked; exchanges ended ok %0d, error %0d, timeout %0d",
             words_seen, exchange_ends[ST_OK], exchange_ends[ST_ERROR],
             exchange_ends[ST_TIMEOUT]);
    $display("%0d result mismatches over %0d cycles", mismatches, cycle_count);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
